// File: rtl/core/e2eac_pkg.sv
// Shared types, constants and the CRC-8 byte step for the end-to-end alive counter guard.
// Depends on nothing; every other file of the block but the checker imports it.
package e2eac_pkg;

  localparam logic [7:0] CrcPoly   = 8'h2F;
  localparam logic [7:0] CrcInit   = 8'hFF;
  localparam logic [7:0] CrcXorOut = 8'hFF;

  localparam logic OpByte    = 1'b0;
  localparam logic OpConfirm = 1'b1;

  localparam logic RoleReceiver    = 1'b0;
  localparam logic RoleTransmitter = 1'b1;

  localparam int unsigned StAliveBit  = 0;
  localparam int unsigned StCsumBit   = 1;
  localparam int unsigned StUninitBit = 2;
  localparam logic [2:0] StatusReset = 3'b100;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] counter_field;
    logic [7:0] received_checksum;
  } in_item_t;

  typedef struct packed {
    logic [7:0] crc_value;
    logic [7:0] header_byte;
    logic [2:0] status;
  } result_t;

  // One message byte through the MSB-first CRC-8 register.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/e2eac_in_stage.sv
// Input register of the guard: captures one item per transfer and holds it until processed.
// Depends on e2eac_pkg.
module e2eac_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  e2eac_pkg::in_item_t item_i,
  input  logic                advance_i,
  output logic                valid_o,
  output e2eac_pkg::in_item_t item_o
);
  import e2eac_pkg::*;

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;
  logic     load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/core/e2eac_guard_core.sv
// Guard state and per-item logic: running CRC, alive counter, status flags and role register.
// Depends on e2eac_pkg for the CRC step, item and result types.
module e2eac_guard_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                valid_i,
  input  e2eac_pkg::in_item_t item_i,
  input  logic                out_free_i,
  output logic                advance_o,
  output logic                res_valid_o,
  output e2eac_pkg::result_t  res_o
);
  import e2eac_pkg::*;

  logic       role_q;
  logic [7:0] crc_q, crc_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] status_q, status_d;
  logic [7:0] crc_next;
  logic [7:0] crc_final;
  logic [7:0] header;
  logic       has_result;

  assign crc_next   = crc8_byte(crc_q, item_i.data_byte);
  assign crc_final  = crc_next ^ CrcXorOut;
  assign has_result = (item_i.op == OpByte) && item_i.last_byte;
  assign advance_o  = valid_i && (!has_result || out_free_i);

  always_comb begin
    crc_d    = crc_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    header   = 8'h00;
    if (advance_o) begin
      if (item_i.op == OpConfirm) begin
        if (role_q == RoleTransmitter) begin
          cnt_d = cnt_q + 4'd1;
        end
      end else if (!item_i.last_byte) begin
        crc_d = crc_next;
      end else begin
        crc_d = CrcInit;
        if (role_q == RoleTransmitter) begin
          header = {cnt_q, item_i.counter_field[3:0]};
          if (status_q[StUninitBit]) begin
            status_d = 3'b000;
          end
        end else begin
          if (status_q[StUninitBit]) begin
            status_d = 3'b000;
            cnt_d    = item_i.counter_field[3:0] + 4'd1;
          end else begin
            status_d[StAliveBit] = item_i.counter_field != {4'b0000, cnt_q};
            cnt_d                = cnt_q + 4'd1;
          end
          status_d[StCsumBit] = item_i.received_checksum != crc_final;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q   <= RoleReceiver;
      crc_q    <= CrcInit;
      cnt_q    <= 4'd0;
      status_q <= StatusReset;
    end else begin
      if (cfg_we_i) begin
        role_q <= cfg_wdata_i;
      end
      crc_q    <= crc_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  assign res_valid_o       = advance_o && has_result;
  assign res_o.crc_value   = crc_final;
  assign res_o.header_byte = header;
  assign res_o.status      = status_d;

endmodule

// File: rtl/core/e2eac_out_stage.sv
// Result register of the guard: holds one result until the receiver takes the transfer.
// Depends on e2eac_pkg for the result type.
module e2eac_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  e2eac_pkg::result_t res_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output e2eac_pkg::result_t res_o
);
  import e2eac_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (free_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/core/e2e_alive_counter_crc8_guard_unit.sv
// Top level of the end-to-end alive counter and CRC-8 guard.
// Depends on e2eac_pkg, e2eac_in_stage, e2eac_guard_core and e2eac_out_stage.
//
// Message bytes arrive on the input channel (in_valid_i, in_stall_o) with op, data_byte,
// last_byte, counter_field and received_checksum. A transfer with op set to the message code
// updates the running CRC-8; the byte flagged last gives one result on the output channel
// (out_valid_o, out_stall_i) carrying crc_value, header_byte and status. A confirmation
// transfer advances the alive counter in transmitter role and gives no result.
// The role register is written through cfg_we_i and cfg_wdata_i; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// An item is taken into the input register, processed from there by the CRC byte step and
// counter logic, and its result is loaded into the result register at the end of the cycle
// in which it is processed; the receiver can then take it.
// One item is accepted every cycle while the input does not stall.
// When the receiver stalls, the held result stays stable; items that give no result still
// flow, and the input stalls only when a finishing item finds the result register full and
// stalled.
// Reset clears the valid flags, sets the running CRC to its initial value, the counter to
// zero, the status to uninitialised and the role to receiver.
module e2e_alive_counter_crc8_guard_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic [7:0] counter_field_i,
  input  logic [7:0] received_checksum_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] crc_value_o,
  output logic [7:0] header_byte_o,
  output logic [2:0] status_o
);
  import e2eac_pkg::*;

  in_item_t in_item;
  in_item_t s1_item;
  logic     s1_valid;
  logic     advance;
  logic     out_free;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.op                = op_i;
  assign in_item.data_byte         = data_byte_i;
  assign in_item.last_byte         = last_byte_i;
  assign in_item.counter_field     = counter_field_i;
  assign in_item.received_checksum = received_checksum_i;

  e2eac_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  e2eac_guard_core u_guard_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (s1_valid),
    .item_i      (s1_item),
    .out_free_i  (out_free),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  e2eac_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign crc_value_o   = out_res.crc_value;
  assign header_byte_o = out_res.header_byte;
  assign status_o      = out_res.status;

endmodule

// File: rtl/core/e2eac_checker.sv
// Port-level checks for the guard, attached to the top level by the bind statement below.
// Depends on e2e_alive_counter_crc8_guard_unit for the port names it observes.
module e2eac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       op_i,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] crc_value_o,
  input logic [7:0] header_byte_o,
  input logic [2:0] status_o
);

  // The result channel is empty after any edge at which reset is held.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // The input only stalls behind a full, stalled result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A transfer that ends no message gives no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (op_i || !last_byte_i)) ##1 !out_valid_o |=> !out_valid_o)
    else $error("result produced by an item that ends no message");

  // A stalled result stays in place unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(crc_value_o) &&
      $stable(header_byte_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind e2e_alive_counter_crc8_guard_unit e2eac_checker u_e2eac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .op_i          (op_i),
  .last_byte_i   (last_byte_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .crc_value_o   (crc_value_o),
  .header_byte_o (header_byte_o),
  .status_o      (status_o)
);

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for e2e_alive_counter_crc8_guard_unit: a queue-fed driver, a monitor and
// a predictor of CRC-8, alive counter and status. Depends on e2eac_pkg and the RTL.
module tb;
  import e2eac_pkg::*;

  localparam int CycleLimit     = 500000;
  localparam int DrainCycles    = 6;
  localparam int LongHoldAfter  = 50;
  localparam int LongHoldCycles = 400;
  localparam int PhaseItems     = 150;
  localparam int NumPhases      = 10;
  localparam int SumGood        = 0;
  localparam int SumFlip        = 1;
  localparam int SumRandom      = 2;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic op_i;
  logic [7:0] data_byte_i;
  logic last_byte_i;
  logic [7:0] counter_field_i;
  logic [7:0] received_checksum_i;
  logic [7:0] crc_value_o;
  logic [7:0] header_byte_o;
  logic [2:0] status_o;

  in_item_t cur_item = '0;
  in_item_t byte_stream_q[$];
  result_t  guard_result_q[$];

  logic       model_role = RoleReceiver;
  logic [7:0] model_crc  = CrcInit;
  logic [3:0] model_alive = 4'h0;
  logic [2:0] model_status = StatusReset;

  logic       gen_role = RoleReceiver;
  logic [3:0] gen_alive = 4'h0;
  int gen_count = 0;

  int tx_gap_max = 19;
  int rx_gap_max = 19;
  int tx_gap = 0;
  int rx_hold = 0;
  int long_hold_left = 0;
  bit long_hold_done = 1'b0;
  int transfers_in = 0;
  int results_seen = 0;
  int rx_msgs = 0;
  int tx_msgs = 0;
  int errors = 0;
  int cycle_count = 0;

  assign op_i                = cur_item.op;
  assign data_byte_i         = cur_item.data_byte;
  assign last_byte_i         = cur_item.last_byte;
  assign counter_field_i     = cur_item.counter_field;
  assign received_checksum_i = cur_item.received_checksum;

  e2e_alive_counter_crc8_guard_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .counter_field_i    (counter_field_i),
    .received_checksum_i(received_checksum_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .crc_value_o        (crc_value_o),
    .header_byte_o      (header_byte_o),
    .status_o           (status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    int i;
    r = crc;
    for (i = 7; i >= 0; i--) begin
      r = {r[6:0], 1'b0} ^ (((r[7] ^ b[i]) != 1'b0) ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  function automatic int draw_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
  endfunction

  task automatic compute_guard_result(input in_item_t it);
    result_t r;
    if (it.op == OpConfirm) begin
      if (model_role == RoleTransmitter) begin
        model_alive = model_alive + 4'd1;
      end
      return;
    end
    model_crc = crc8_next(model_crc, it.data_byte);
    if (!it.last_byte) begin
      return;
    end
    r.crc_value = model_crc ^ CrcXorOut;
    model_crc = CrcInit;
    if (model_role == RoleTransmitter) begin
      tx_msgs++;
      r.header_byte = {model_alive, it.counter_field[3:0]};
      if (model_status == StatusReset) begin
        model_status = 3'b000;
      end
    end else begin
      rx_msgs++;
      r.header_byte = 8'h00;
      if (model_status == StatusReset) begin
        model_alive = it.counter_field[3:0];
        model_status = 3'b000;
      end else begin
        model_status[StAliveBit] = (it.counter_field != {4'h0, model_alive});
      end
      model_status[StCsumBit] = (it.received_checksum != r.crc_value);
      model_alive = model_alive + 4'd1;
    end
    r.status = model_status;
    guard_result_q.push_back(r);
  endtask

  task automatic push_item(input logic op, input logic [7:0] data, input logic last,
                           input logic [7:0] cnt, input logic [7:0] rcs);
    in_item_t it;
    it.op = op;
    it.data_byte = data;
    it.last_byte = last;
    it.counter_field = cnt;
    it.received_checksum = rcs;
    byte_stream_q.push_back(it);
    if (op == OpConfirm && gen_role == RoleTransmitter) begin
      gen_alive = gen_alive + 4'd1;
    end
    if (!(op == OpConfirm && gen_role == RoleReceiver)) begin
      gen_count++;
    end
  endtask

  task automatic push_message(input int len, input logic [7:0] cnt, input int sum_mode);
    logic [7:0] run;
    logic [7:0] d;
    logic [7:0] rcs;
    int k;
    run = CrcInit;
    for (k = 0; k < len; k++) begin
      d = 8'($urandom);
      run = crc8_next(run, d);
      if (k == len - 1) begin
        case (sum_mode)
          SumGood: rcs = run ^ CrcXorOut;
          SumFlip: rcs = run ^ CrcXorOut ^ (8'd1 << $urandom_range(0, 7));
          default: rcs = 8'($urandom);
        endcase
        push_item(OpByte, d, 1'b1, cnt, rcs);
      end else begin
        push_item(OpByte, d, 1'b0, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 19) == 0) begin
          push_item(OpConfirm, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
    if (gen_role == RoleReceiver) begin
      gen_alive = gen_alive + 4'd1;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (byte_stream_q.size() != 0 || in_valid_i || guard_result_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_role(input logic r);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_role = r;
    gen_role = r;
    repeat (2) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        compute_guard_result(cur_item);
        transfers_in <= transfers_in + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (byte_stream_q.size() != 0) begin
          cur_item <= byte_stream_q.pop_front();
          in_valid_i <= 1'b1;
          tx_gap <= (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : rx_side
    int hold_next;
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold <= 0;
    end else begin
      hold_next = rx_hold;
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (guard_result_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: crc %02h header %02h status %03b",
                     crc_value_o, header_byte_o, status_o);
          end
        end else begin
          want = guard_result_q.pop_front();
          if (want.crc_value !== crc_value_o || want.header_byte !== header_byte_o ||
              want.status !== status_o) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at result %0d: crc %02h/%02h header %02h/%02h status %03b/%03b",
                       results_seen, want.crc_value, crc_value_o, want.header_byte,
                       header_byte_o, want.status, status_o);
            end
          end
        end
        hold_next = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
      end else if (hold_next > 0) begin
        hold_next = hold_next - 1;
      end
      rx_hold <= hold_next;
      out_stall_i <= (long_hold_left != 0) || (hold_next > 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      long_hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && results_seen >= LongHoldAfter) begin
      long_hold_left <= LongHoldCycles;
      long_hold_done <= 1'b1;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, guard_result_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int start;
    int pick;
    logic rsel;
    logic [7:0] dsum;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_role(RoleReceiver);

    // The first message adopts a wide counter, of which only the low nibble is kept.
    dsum = crc8_next(crc8_next(crc8_next(CrcInit, 8'h00), 8'hFF), 8'h80) ^ CrcXorOut;
    push_item(OpByte, 8'h00, 1'b0, 8'h00, 8'h00);
    push_item(OpByte, 8'hFF, 1'b0, 8'hFF, 8'hFF);
    push_item(OpByte, 8'h80, 1'b1, 8'hFF, dsum);
    push_item(OpConfirm, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    dsum = crc8_next(CrcInit, 8'h00) ^ CrcXorOut;
    push_item(OpByte, 8'h00, 1'b1, 8'h00, ~dsum);
    dsum = crc8_next(CrcInit, 8'hFF) ^ CrcXorOut;
    push_item(OpByte, 8'hFF, 1'b1, 8'h11, dsum);
    dsum = crc8_next(CrcInit, 8'h5A) ^ CrcXorOut;
    push_item(OpByte, 8'h5A, 1'b1, 8'h02, dsum);
    // The role changes between the bytes of one message; the CRC carries on.
    push_item(OpByte, 8'hA5, 1'b0, 8'h00, 8'hFF);
    push_item(OpByte, 8'h3C, 1'b0, 8'hFF, 8'h00);
    wait_idle();
    write_role(RoleTransmitter);
    push_item(OpByte, 8'h01, 1'b1, 8'hFF, 8'h00);
    push_item(OpConfirm, 8'h00, 1'b1, 8'h00, 8'h00);
    push_item(OpConfirm, 8'hFF, 1'b0, 8'hFF, 8'hFF);
    push_item(OpByte, 8'h00, 1'b1, 8'h00, 8'h00);
    push_item(OpConfirm, 8'h80, 1'b1, 8'h0F, 8'h80);
    push_item(OpByte, 8'hFF, 1'b0, 8'hF0, 8'hFF);
    push_item(OpByte, 8'hFF, 1'b1, 8'hF0, 8'hFF);
    wait_idle();
    write_role(RoleReceiver);
    gen_alive = 4'h6;
    push_message(2, 8'h06, SumGood);
    wait_idle();

    for (p = 0; p < NumPhases; p++) begin
      rsel = (p % 4 == 3) ? logic'($urandom_range(0, 1)) : logic'(p % 2);
      write_role(rsel);
      case (p % 4)
        0: begin tx_gap_max <= 19; rx_gap_max <= 19; end
        1: begin tx_gap_max <= 0;  rx_gap_max <= 0;  end
        2: begin tx_gap_max <= 0;  rx_gap_max <= 19; end
        default: begin tx_gap_max <= 19; rx_gap_max <= 0; end
      endcase
      start = gen_count;
      while (gen_count - start < PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (gen_role == RoleReceiver) begin
          if (pick < 80) begin
            push_message(draw_length(), {4'h0, gen_alive}, SumGood);
          end else if (pick < 88) begin
            push_message(draw_length(), 8'($urandom), SumGood);
          end else if (pick < 95) begin
            push_message(draw_length(), {4'h0, gen_alive}, SumFlip);
          end else begin
            push_item(OpConfirm, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
          end
        end else if (pick < 25) begin
          push_item(OpConfirm, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          push_message(draw_length(), 8'($urandom), SumRandom);
        end
      end
      wait_idle();
    end

    $display("covered %0d input transfers and %0d results in %0d cycles",
             transfers_in, results_seen, cycle_count);
    $display("messages checked in receiver role: %0d, protected in transmitter role: %0d",
             rx_msgs, tx_msgs);
    if (errors == 0 && guard_result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
